// ===== design/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

   localparam int SYM_W              = 8;
   localparam int LEN_W              = 6;
   localparam int BYTE_W             = 8;
   localparam int WORD_W_MAX         = 32;
   localparam int TABLE_DEPTH        = 256;
   localparam int MAX_CODE_LEN_DFLT  = 32;
   localparam int REQ_DATA_W         = 48;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Control side of an item leaving the table lookup stage.
   typedef struct packed {
      logic              valid;
      logic              flush;
      logic [LEN_W-1:0]  len;
   } item_type;

endpackage

// ===== design/hcbp_code_table.sv =====
// Code table memory with its registered lookup stage.
module hcbp_code_table #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DFLT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  hcbp_pkg::cmd_type             cmd,
   input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
   input  logic [31:0]                   code_word,
   input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
   input  logic                          item_take,
   output logic                          busy,
   output hcbp_pkg::item_type            item,
   output logic [((MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32)-1:0] item_bits
);

   localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::WORD_W_MAX) ?
                           MAX_CODE_LEN : hcbp_pkg::WORD_W_MAX;
   localparam logic [hcbp_pkg::LEN_W-1:0] LEN_MAX = hcbp_pkg::LEN_W'(CODE_W);

   logic [CODE_W-1:0]          bits_mem [hcbp_pkg::TABLE_DEPTH];
   logic [hcbp_pkg::LEN_W-1:0] len_mem  [hcbp_pkg::TABLE_DEPTH];

   logic [CODE_W-1:0]          rd_bits_ff;
   logic [hcbp_pkg::LEN_W-1:0] rd_len_ff;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_flush_ff, s1_flush_in;

   logic [hcbp_pkg::LEN_W-1:0] wr_len;
   logic [CODE_W-1:0]          wr_bits;
   logic [CODE_W-1:0]          wr_mask;

   always_comb begin
      wr_len = (code_length > LEN_MAX) ? LEN_MAX : code_length;
      for (int i = 0; i < CODE_W; i++) begin
         wr_mask[i] = (hcbp_pkg::LEN_W'(i) < wr_len);
      end
      wr_bits = code_word[CODE_W-1:0] & wr_mask;
   end

   // Writes and reads both happen at the accepting edge, so a lookup always
   // sees every load accepted before it.
   always_ff @(posedge clock) begin
      if (accept && cmd == hcbp_pkg::CMD_LOAD) begin
         bits_mem[symbol] <= wr_bits;
         len_mem[symbol]  <= wr_len;
      end
      if (accept) begin
         rd_bits_ff <= bits_mem[symbol];
         rd_len_ff  <= len_mem[symbol];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_flush_in = s1_flush_ff;
      if (item_take) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = (cmd == hcbp_pkg::CMD_ENCODE) || (cmd == hcbp_pkg::CMD_FLUSH);
         s1_flush_in = (cmd == hcbp_pkg::CMD_FLUSH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_flush_ff <= s1_flush_in;
   end

   assign busy       = s1_valid_ff && !item_take;
   assign item.valid = s1_valid_ff;
   assign item.flush = s1_flush_ff;
   assign item.len   = (rd_len_ff > LEN_MAX) ? LEN_MAX : rd_len_ff;
   assign item_bits  = rd_bits_ff;

endmodule

// ===== design/hcbp_packer.sv =====
// Bit accumulator and output byte register.
module hcbp_packer #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DFLT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hcbp_pkg::item_type             item,
   input  logic [((MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32)-1:0] item_bits,
   output logic                           item_take,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hcbp_pkg::BYTE_W-1:0]    rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::WORD_W_MAX) ?
                           MAX_CODE_LEN : hcbp_pkg::WORD_W_MAX;
   localparam int ACC_W  = CODE_W + hcbp_pkg::BYTE_W - 1;
   localparam int CNT_W  = $clog2(ACC_W + 1);
   localparam int PEND_W = hcbp_pkg::BYTE_W - 1;
   localparam logic [CNT_W-1:0] CNT_BYTE = CNT_W'(hcbp_pkg::BYTE_W);

   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        out_valid_ff, out_valid_in;
   logic [hcbp_pkg::BYTE_W-1:0] out_data_ff, out_data_in;
   logic                        out_last_ff, out_last_in;

   logic                        out_free;
   logic                        emit_now;
   logic [CNT_W-1:0]            cnt_after;
   logic [PEND_W-1:0]           pend_mask;
   logic [PEND_W-1:0]           pend;
   logic [CNT_W-1:0]            byte_shift;
   logic [CNT_W-1:0]            flush_shift;
   logic [hcbp_pkg::BYTE_W-1:0] emit_byte;
   logic [hcbp_pkg::BYTE_W-1:0] flush_byte;

   always_comb begin
      out_free    = !out_valid_ff || rsp_tready;
      emit_now    = (cnt_ff >= CNT_BYTE) && out_free;
      cnt_after   = emit_now ? (cnt_ff - CNT_BYTE) : cnt_ff;
      for (int i = 0; i < PEND_W; i++) begin
         pend_mask[i] = (CNT_W'(i) < cnt_after);
      end
      // Bits above the pending count are stale and are masked off here.
      pend        = acc_ff[PEND_W-1:0] & pend_mask;
      byte_shift  = cnt_ff - CNT_BYTE;
      emit_byte   = hcbp_pkg::BYTE_W'(acc_ff >> byte_shift);
      flush_shift = CNT_BYTE - cnt_after;
      flush_byte  = hcbp_pkg::BYTE_W'({1'b0, pend} << flush_shift);
      item_take   = item.valid && (cnt_after < CNT_BYTE);

      acc_in = acc_ff;
      cnt_in = cnt_after;
      if (item_take) begin
         if (item.flush) begin
            // A flush turns the partial byte into a full padded byte that
            // drains like any other.
            if (cnt_after != '0) begin
               acc_in = ACC_W'(flush_byte);
               cnt_in = CNT_BYTE;
            end else begin
               acc_in = '0;
               cnt_in = '0;
            end
         end else begin
            acc_in = (ACC_W'(pend) << item.len) | ACC_W'(item_bits);
            cnt_in = cnt_after + CNT_W'(item.len);
         end
      end

      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (emit_now) begin
         out_valid_in = 1'b1;
         out_data_in  = emit_byte;
         out_last_in  = (cnt_after < CNT_BYTE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ACC_W))
      else $error("accumulator count out of range");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= CNT_BYTE && out_free) |=> out_valid_ff)
      else $error("full byte not moved to output register");

   a_flush: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.flush) |=> (cnt_ff == '0 || cnt_ff == CNT_BYTE))
      else $error("flush left a partial byte");
`endif

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// Huffman code bit packer: code table lookup feeding a byte packer.
// A byte passes from the lookup register through the accumulator to the output register.
// Throughput: one output byte per cycle while rsp_tready is high; the single output
// port drains up to 4 bytes of a 32-bit code, and later beats wait until it has.
// Load beats only write the table; flush beats pass through to the packer.
// Reset clears the accumulator and pipeline; the code table holds no reset.
module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DFLT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] symbol, [39:8] code_word, [45:40] code_length, [47:46] zero
   input  logic [hcbp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] cmd
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] out_byte
   output logic [hcbp_pkg::BYTE_W-1:0]        rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::WORD_W_MAX) ?
                           MAX_CODE_LEN : hcbp_pkg::WORD_W_MAX;

   logic                 accept;
   logic                 busy;
   logic                 item_take;
   hcbp_pkg::item_type   item;
   logic [CODE_W-1:0]    item_bits;
   hcbp_pkg::cmd_type    cmd;

   assign cmd        = hcbp_pkg::cmd_type'(req_tuser);
   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   hcbp_code_table #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (cmd),
      .symbol      (req_tdata[7:0]),
      .code_word   (req_tdata[39:8]),
      .code_length (req_tdata[45:40]),
      .item_take   (item_take),
      .busy        (busy),
      .item        (item),
      .item_bits   (item_bits)
   );

   hcbp_packer #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_packer (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_bits  (item_bits),
      .item_take  (item_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
